>>> rtl/wlft_pkg.sv
// Shared constants and types for the weekly low-flow tracker.
package wlft_pkg;

  localparam int WINDOW_DAYS = 7;
  localparam int FLOW_BITS   = 24;

  localparam int YEAR_BITS  = 12;
  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS   = 5;
  localparam int COUNT_BITS = 4;

  localparam int PTR_BITS = $clog2(WINDOW_DAYS);
  localparam int SUM_BITS = FLOW_BITS + $clog2(WINDOW_DAYS);

  // Division by the window length as multiply by a rounded-up reciprocal.
  localparam int RECIP_SHIFT = SUM_BITS + $clog2(WINDOW_DAYS);
  localparam int RECIP_BITS  = RECIP_SHIFT - $clog2(WINDOW_DAYS) + 1;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_DAYS) - 64'd1) / 64'(WINDOW_DAYS);
  localparam logic [RECIP_BITS-1:0] RECIP_MULT = RECIP_WIDE[RECIP_BITS-1:0];
  localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 64;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Register index as decoded from paddr[2].
  localparam logic REG_START_YEAR = 1'b0;
  localparam logic REG_WY_MONTH   = 1'b1;

  localparam logic [MONTH_BITS-1:0] WY_MONTH_RST = MONTH_BITS'(10);
  localparam logic [DAY_BITS-1:0]   FIRST_DAY    = DAY_BITS'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
  localparam logic [COUNT_BITS-1:0] FULL_YEAR    = COUNT_BITS'(12);

  typedef struct packed {
    logic [YEAR_BITS-1:0]  start_year;
    logic [MONTH_BITS-1:0] wy_month;
  } cfg_t;

endpackage

>>> rtl/weekly_low_flow_tracker_unit.sv
// Result path: the item that closes a water year passes the stage 1 register, then loads the output register.
// Throughput: one item per cycle; the flow window RAM read and write-back keep pace each cycle.
// Input stalls only when a report meets an output register that is full and not being taken.
// Reset: window entries are marked empty by per-entry valid bits and read as zero, no sweep;
// sum clears, minimum arms at all ones, tracking and month count clear, start year 0, month 10.
module weekly_low_flow_tracker_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: sample_year[11:0], sample_month[15:12], sample_day[20:16], flow[44:21], zero pad
  input  logic [wlft_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: low_week_average[23:0], low_year[35:24], low_month[39:36], low_day[44:40],
  //        report_year[56:45], months_seen[60:57], year_complete[61], zero pad
  output logic [wlft_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wlft_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [wlft_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [wlft_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  localparam int YB = wlft_pkg::YEAR_BITS;
  localparam int MB = wlft_pkg::MONTH_BITS;
  localparam int DB = wlft_pkg::DAY_BITS;
  localparam int FB = wlft_pkg::FLOW_BITS;
  localparam int CB = wlft_pkg::COUNT_BITS;
  localparam int SB = wlft_pkg::SUM_BITS;
  localparam int PB = wlft_pkg::PTR_BITS;
  localparam int WD = wlft_pkg::WINDOW_DAYS;

  wlft_pkg::cfg_t cfg;

  wlft_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------- stage 0
  // Unpack the item, drop early years, and read the window slot being replaced.
  logic [YB-1:0] in_year;
  logic [MB-1:0] in_month;
  logic [DB-1:0] in_day;
  logic [FB-1:0] in_flow;
  logic          in_acc;
  logic          push0;

  assign in_year  = s_axis_tdata[0 +: YB];
  assign in_month = s_axis_tdata[YB +: MB];
  assign in_day   = s_axis_tdata[YB+MB +: DB];
  assign in_flow  = s_axis_tdata[YB+MB+DB +: FB];

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign push0  = in_acc && (in_year >= cfg.start_year);

  // Window write pointer: advances once per kept item, wraps at the window length.
  logic [PB-1:0] ptr_q, ptr_d;

  always_comb begin
    ptr_d = ptr_q;
    if (push0) begin
      ptr_d = (ptr_q == PB'(WD - 1)) ? '0 : ptr_q + PB'(1);
    end
  end

  // Per-entry valid bits stand in for the all-zero window reset.
  logic [WD-1:0] win_vld_q, win_vld_d;

  // ---------------------------------------------------------------- stage 1
  logic          s1_valid_q, s1_valid_d;
  logic [YB-1:0] s1_year_q;
  logic [MB-1:0] s1_month_q;
  logic [DB-1:0] s1_day_q;
  logic [FB-1:0] s1_flow_q;
  logic [PB-1:0] s1_addr_q;
  logic          s1_wy_q;
  logic          s1_old_vld_q;

  logic [FB-1:0] ram_rdata;
  logic [FB-1:0] old_flow;
  logic          s1_report;
  logic          s1_stall;
  logic          s1_adv;

  wlft_ram #(
    .WIDTH (FB),
    .DEPTH (WD)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_flow_q),
    .re_i    (push0),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Slots never written since reset count as zero flow.
  assign old_flow = s1_old_vld_q ? ram_rdata : '0;

  // Tracker state.
  logic          tracking_q, tracking_d;
  logic [SB-1:0] sum_q, sum_d;
  logic [SB-1:0] least_q, least_d;
  logic [YB-1:0] least_year_q, least_year_d;
  logic [MB-1:0] least_month_q, least_month_d;
  logic [DB-1:0] least_day_q, least_day_d;
  logic [CB-1:0] mcount_q, mcount_d;

  logic          month_inc;
  logic [CB-1:0] mcount_now;
  logic [SB-1:0] sum_next;
  logic [SB-1:0] least_base;
  logic          cmp_en;
  logic          take_min;
  logic          least_armed;

  // A water-year start only closes a year once tracking has begun.
  assign s1_report = s1_valid_q && tracking_q && s1_wy_q;
  // Hold stage 1 while a report cannot enter the output register.
  assign s1_stall  = s1_report && m_axis_tvalid && !m_axis_tready;
  assign s1_adv    = s1_valid_q && !s1_stall;
  assign s_axis_tready = !s1_stall;

  assign month_inc  = (s1_day_q == wlft_pkg::FIRST_DAY) && (mcount_q != wlft_pkg::COUNT_MAX);
  assign mcount_now = mcount_q + CB'(month_inc);

  // Sum stays exact: the old slot is always part of the current sum.
  assign sum_next   = sum_q - SB'(old_flow) + SB'(s1_flow_q);
  // Rearm the minimum on any water-year start before comparing.
  assign least_base = s1_wy_q ? '1 : least_q;
  assign cmp_en     = tracking_q || s1_wy_q;
  assign take_min   = cmp_en && (sum_next < least_base);
  assign least_armed = (least_q == '1);

  always_comb begin
    tracking_d    = tracking_q;
    sum_d         = sum_q;
    least_d       = least_q;
    least_year_d  = least_year_q;
    least_month_d = least_month_q;
    least_day_d   = least_day_q;
    mcount_d      = mcount_q;
    win_vld_d     = win_vld_q;
    if (s1_adv) begin
      sum_d                = sum_next;
      win_vld_d[s1_addr_q] = 1'b1;
      if (s1_wy_q) begin
        tracking_d = 1'b1;
        mcount_d   = '0;
      end else if (tracking_q) begin
        mcount_d = mcount_now;
      end
      if (cmp_en) begin
        least_d = least_base;
      end
      if (take_min) begin
        least_d       = sum_next;
        least_year_d  = s1_year_q;
        least_month_d = s1_month_q;
        least_day_d   = s1_day_q;
      end
    end
  end

  // Advance stage 1 whenever it is not held; empty it when nothing kept arrives.
  assign s1_valid_d = s1_stall ? s1_valid_q : push0;

  // ---------------------------------------------------------------- output
  logic [FB-1:0] avg;

  wlft_avg u_avg (
    .sum_i (least_q),
    .avg_o (avg)
  );

  logic          out_valid_q, out_valid_d;
  logic [FB-1:0] out_avg_q;
  logic [YB-1:0] out_low_year_q;
  logic [MB-1:0] out_low_month_q;
  logic [DB-1:0] out_low_day_q;
  logic [YB-1:0] out_rep_year_q;
  logic [CB-1:0] out_months_q;
  logic          out_complete_q;
  logic          out_load;

  assign out_load = s1_adv && s1_report;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    {(wlft_pkg::OUT_DATA_BITS - (FB + 2*YB + MB + DB + CB + 1)){1'b0}},
    out_complete_q, out_months_q, out_rep_year_q,
    out_low_day_q, out_low_month_q, out_low_year_q, out_avg_q
  };

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q         <= '0;
      win_vld_q     <= '0;
      s1_valid_q    <= 1'b0;
      tracking_q    <= 1'b0;
      sum_q         <= '0;
      least_q       <= '1;
      least_year_q  <= '0;
      least_month_q <= '0;
      least_day_q   <= '0;
      mcount_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      ptr_q         <= ptr_d;
      win_vld_q     <= win_vld_d;
      s1_valid_q    <= s1_valid_d;
      tracking_q    <= tracking_d;
      sum_q         <= sum_d;
      least_q       <= least_d;
      least_year_q  <= least_year_d;
      least_month_q <= least_month_d;
      least_day_q   <= least_day_d;
      mcount_q      <= mcount_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload: stage 1 item and output fields.
  always_ff @(posedge clk_i) begin
    if (push0 && !s1_stall) begin
      s1_year_q    <= in_year;
      s1_month_q   <= in_month;
      s1_day_q     <= in_day;
      s1_flow_q    <= in_flow;
      s1_addr_q    <= ptr_q;
      s1_wy_q      <= (in_month == cfg.wy_month) && (in_day == wlft_pkg::FIRST_DAY);
      s1_old_vld_q <= win_vld_q[ptr_q];
    end
    if (out_load) begin
      out_avg_q       <= least_armed ? '1 : avg;
      out_low_year_q  <= least_armed ? '0 : least_year_q;
      out_low_month_q <= least_armed ? '0 : least_month_q;
      out_low_day_q   <= least_armed ? '0 : least_day_q;
      out_rep_year_q  <= s1_year_q;
      out_months_q    <= mcount_now;
      out_complete_q  <= (mcount_now == wlft_pkg::FULL_YEAR);
    end
  end

  // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
  // Input back-pressure only comes from a blocked output register.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked output");

  // Write-back and new read never hit the same window slot.
  a_ram_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && push0) |-> (s1_addr_q != ptr_q))
    else $error("window RAM read and write collide");

  // Pointer stays inside the window.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PB'(WD - 1))
    else $error("window pointer out of range");

  // A report leaves tracking on and the month count cleared.
  a_report_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (tracking_q && (mcount_q == '0)))
    else $error("report did not rearm the year");
`endif

endmodule

>>> rtl/wlft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wlft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/wlft_cfg.sv
// APB register file: start year and water-year month.
module wlft_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wlft_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [wlft_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [wlft_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output wlft_pkg::cfg_t                     cfg_o
);

  wlft_pkg::cfg_t cfg_q;
  wlft_pkg::cfg_t cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        wlft_pkg::REG_START_YEAR: cfg_d.start_year = pwdata[wlft_pkg::YEAR_BITS-1:0];
        wlft_pkg::REG_WY_MONTH:   cfg_d.wy_month   = pwdata[wlft_pkg::MONTH_BITS-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_year <= '0;
      cfg_q.wy_month   <= wlft_pkg::WY_MONTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      wlft_pkg::REG_START_YEAR:
        prdata = {{(wlft_pkg::APB_DATA_BITS - wlft_pkg::YEAR_BITS){1'b0}}, cfg_q.start_year};
      wlft_pkg::REG_WY_MONTH:
        prdata = {{(wlft_pkg::APB_DATA_BITS - wlft_pkg::MONTH_BITS){1'b0}}, cfg_q.wy_month};
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/wlft_avg.sv
// Window sum to average: multiply by reciprocal of the window length.
module wlft_avg (
  input  logic [wlft_pkg::SUM_BITS-1:0]  sum_i,
  output logic [wlft_pkg::FLOW_BITS-1:0] avg_o
);

  logic [wlft_pkg::PROD_BITS-1:0] prod;

  // Exact floor for every sum below 2**SUM_BITS.
  assign prod  = wlft_pkg::PROD_BITS'(sum_i) * wlft_pkg::PROD_BITS'(wlft_pkg::RECIP_MULT);
  assign avg_o = prod[wlft_pkg::RECIP_SHIFT +: wlft_pkg::FLOW_BITS];

endmodule

>>> bench/tb_weekly_low_flow_tracker_unit.sv
// Self-checking stream testbench for the weekly low-flow tracker unit.
module tb_weekly_low_flow_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 290;
  localparam int SETTLE_TICKS = 8;
  localparam logic [wlft_pkg::SUM_BITS-1:0] LEAST_ARMED = '1;

  // One daily sample as it travels on s_axis_tdata, year in the lowest bits.
  typedef struct packed {
    logic [2:0]                      pad;
    logic [wlft_pkg::FLOW_BITS-1:0]  flow;
    logic [wlft_pkg::DAY_BITS-1:0]   day;
    logic [wlft_pkg::MONTH_BITS-1:0] month;
    logic [wlft_pkg::YEAR_BITS-1:0]  year;
  } daily_sample_t;

  // One water-year summary as it travels on m_axis_tdata.
  typedef struct packed {
    logic [1:0]                      pad;
    logic                            complete;
    logic [wlft_pkg::COUNT_BITS-1:0] months_seen;
    logic [wlft_pkg::YEAR_BITS-1:0]  report_year;
    logic [wlft_pkg::DAY_BITS-1:0]   low_day;
    logic [wlft_pkg::MONTH_BITS-1:0] low_month;
    logic [wlft_pkg::YEAR_BITS-1:0]  low_year;
    logic [wlft_pkg::FLOW_BITS-1:0]  low_avg;
  } low_flow_report_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  // tdata: sample_year, sample_month, sample_day, flow, zero pad (lowest bit up)
  logic [wlft_pkg::IN_DATA_BITS-1:0]  s_axis_tdata;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  // tdata: low_week_average, low_year, low_month, low_day, report_year,
  //        months_seen, year_complete, zero pad (lowest bit up)
  logic [wlft_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [wlft_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [wlft_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [wlft_pkg::APB_DATA_BITS-1:0] prdata;
  logic                               pready;

  weekly_low_flow_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Mirror of the block's registers, updated on the APB write edge.
  logic [wlft_pkg::YEAR_BITS-1:0]  cfg_start_year = '0;
  logic [wlft_pkg::MONTH_BITS-1:0] cfg_wy_month   = wlft_pkg::WY_MONTH_RST;

  // Shadow state of the tracker.
  logic [wlft_pkg::FLOW_BITS-1:0]  window_flow [wlft_pkg::WINDOW_DAYS];
  int                              window_slot  = 0;
  logic [wlft_pkg::SUM_BITS-1:0]   week_sum     = '0;
  logic [wlft_pkg::SUM_BITS-1:0]   least_week   = LEAST_ARMED;
  logic [20:0]                     least_stamp  = '0;
  logic [wlft_pkg::COUNT_BITS-1:0] month_starts = '0;
  bit                              tracking     = 1'b0;

  daily_sample_t    samples_to_send[$];
  low_flow_report_t reports_due[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  mismatches    = 0;
  int  cycle_count   = 0;
  bit  in_taken      = 1'b0;

  initial begin
    foreach (window_flow[i]) window_flow[i] = '0;
  end

  // Shift one flow into the 7-day window and keep the running sum exact.
  task automatic push_window(input logic [wlft_pkg::FLOW_BITS-1:0] flow);
    week_sum = week_sum - wlft_pkg::SUM_BITS'(window_flow[window_slot])
             + wlft_pkg::SUM_BITS'(flow);
    window_flow[window_slot] = flow;
    window_slot = (window_slot + 1) % wlft_pkg::WINDOW_DAYS;
  endtask

  // Advance the shadow tracker by one accepted sample; flag a water-year summary.
  task automatic predict_low_flow_report(input daily_sample_t s, output bit fired,
                                         output low_flow_report_t rep);
    bit wy_start;
    fired = 1'b0;
    rep = '0;
    wy_start = (s.month == cfg_wy_month) && (s.day == wlft_pkg::FIRST_DAY);
    if (s.year < cfg_start_year) return;
    if (!tracking) begin
      // Before the first water-year start, samples only prime the window.
      if (!wy_start) begin
        push_window(s.flow);
        return;
      end
      tracking = 1'b1;
      month_starts = '0;
      least_week = LEAST_ARMED;
    end else begin
      // Count the month start first, so a full year closes with twelve.
      if (s.day == wlft_pkg::FIRST_DAY && month_starts != wlft_pkg::COUNT_MAX)
        month_starts++;
      if (wy_start) begin
        fired = 1'b1;
        if (least_week == LEAST_ARMED) begin
          rep.low_avg = '1;
        end else begin
          rep.low_avg = wlft_pkg::FLOW_BITS'(least_week / wlft_pkg::WINDOW_DAYS);
          {rep.low_year, rep.low_month, rep.low_day} = least_stamp;
        end
        rep.report_year = s.year;
        rep.months_seen = month_starts;
        rep.complete    = (month_starts == wlft_pkg::FULL_YEAR);
        month_starts = '0;
        least_week = LEAST_ARMED;
      end
    end
    // The start sample belongs to the new year: it enters the window and the minimum.
    push_window(s.flow);
    if (week_sum < least_week) begin
      least_week = week_sum;
      least_stamp = {s.year, s.month, s.day};
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: present items from the pending queue, drop valid on sender idle cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= samples_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: track register writes, predict on input items, check output items.
  always @(posedge clk_i) begin
    daily_sample_t    taken;
    low_flow_report_t seen;
    low_flow_report_t want;
    low_flow_report_t rep;
    bit               fired;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          wlft_pkg::REG_START_YEAR:
            cfg_start_year = pwdata[wlft_pkg::YEAR_BITS-1:0];
          wlft_pkg::REG_WY_MONTH:
            cfg_wy_month   = pwdata[wlft_pkg::MONTH_BITS-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata;
        if (reports_due.size() == 0) begin
          $error("unexpected report: tdata 0x%0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          compare_field("low_week_average", want.low_avg,     seen.low_avg);
          compare_field("low_year",         want.low_year,    seen.low_year);
          compare_field("low_month",        want.low_month,   seen.low_month);
          compare_field("low_day",          want.low_day,     seen.low_day);
          compare_field("report_year",      want.report_year, seen.report_year);
          compare_field("months_seen",      want.months_seen, seen.months_seen);
          compare_field("year_complete",    want.complete,    seen.complete);
          compare_field("zero pad",         0,                seen.pad);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        taken = s_axis_tdata;
        predict_low_flow_report(taken, fired, rep);
        if (fired) reports_due.push_back(rep);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus helpers.
  task automatic queue_sample(input logic [wlft_pkg::YEAR_BITS-1:0] year, input int month,
                              input int day, input logic [wlft_pkg::FLOW_BITS-1:0] flow);
    daily_sample_t s;
    s = '0;
    s.year  = year;
    s.month = wlft_pkg::MONTH_BITS'(month);
    s.day   = wlft_pkg::DAY_BITS'(day);
    s.flow  = flow;
    samples_to_send.push_back(s);
  endtask

  function automatic logic [wlft_pkg::FLOW_BITS-1:0] draw_flow();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return wlft_pkg::FLOW_BITS'($urandom_range(255));
      default: return wlft_pkg::FLOW_BITS'($urandom());
    endcase
  endfunction

  function automatic int month_length(input logic [wlft_pkg::YEAR_BITS-1:0] year,
                                      input int month);
    bit leap;
    leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    case (month)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic logic [wlft_pkg::YEAR_BITS-1:0] year_near_start();
    if (cfg_start_year < wlft_pkg::YEAR_BITS'(4000))
      return cfg_start_year + wlft_pkg::YEAR_BITS'($urandom_range(2));
    return cfg_start_year;
  endfunction

  // Well-formed calendar walk: prime a few days before the water-year month,
  // then month after month with day 1 and a handful of later days, some months dense.
  task automatic queue_season();
    logic [wlft_pkg::YEAR_BITS-1:0] yr;
    int mo;
    int dim;
    int d;
    int n_months;
    yr = year_near_start();
    if ($urandom_range(7) == 0) yr = cfg_start_year - 1'b1;
    mo = (cfg_wy_month >= 1 && cfg_wy_month <= 12) ? cfg_wy_month : $urandom_range(1, 12);
    if (mo == 1) begin
      mo = 12;
      yr = yr - 1'b1;
    end else begin
      mo = mo - 1;
    end
    dim = month_length(yr, mo);
    for (d = dim - $urandom_range(9); d <= dim; d++) queue_sample(yr, mo, d, draw_flow());
    n_months = $urandom_range(4, 20);
    repeat (n_months) begin
      if (mo == 12) begin
        mo = 1;
        yr = yr + 1'b1;
      end else begin
        mo++;
      end
      dim = month_length(yr, mo);
      if ($urandom_range(9) == 0) begin
        for (d = 1; d <= dim; d++) queue_sample(yr, mo, d, draw_flow());
      end else begin
        // Drop a month start now and then, or repeat one.
        if ($urandom_range(29) != 0) queue_sample(yr, mo, 1, draw_flow());
        if ($urandom_range(29) == 0) queue_sample(yr, mo, 1, draw_flow());
        d = 1;
        repeat ($urandom_range(1, 4)) begin
          d += $urandom_range(1, 9);
          if (d <= dim) queue_sample(yr, mo, d, draw_flow());
        end
      end
    end
  endtask

  // Broken sequence: a run of day-1 samples (can saturate the month count), then a start.
  task automatic queue_month_start_burst();
    logic [wlft_pkg::YEAR_BITS-1:0] yr;
    int mo;
    yr = year_near_start();
    repeat ($urandom_range(3, 18)) begin
      do mo = $urandom_range(15); while (mo == cfg_wy_month);
      queue_sample(yr, mo, 1, draw_flow());
    end
    queue_sample(yr, cfg_wy_month, 1, draw_flow());
  endtask

  task automatic queue_noise(input int count);
    logic [wlft_pkg::YEAR_BITS-1:0] yr;
    repeat (count) begin
      yr = $urandom_range(1) ? year_near_start() : wlft_pkg::YEAR_BITS'($urandom());
      queue_sample(yr, $urandom_range(15), $urandom_range(31), draw_flow());
    end
  endtask

  // Hold until every item is sent and every report is checked, then let the pipe empty.
  task automatic let_block_settle();
    while (samples_to_send.size() != 0 || s_axis_tvalid || reports_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_register(input logic index,
                                input logic [wlft_pkg::APB_DATA_BITS-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [wlft_pkg::YEAR_BITS-1:0]  start_table [6];
    logic [wlft_pkg::MONTH_BITS-1:0] month_table [6];

    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Register settings per phase: extremes of both fields, odd month codes, random.
    start_table = '{12'd0, 12'd4095, 12'd2000, 12'd0,
                    wlft_pkg::YEAR_BITS'($urandom_range(4000)),
                    wlft_pkg::YEAR_BITS'($urandom_range(4000))};
    month_table = '{4'd1, 4'd12, 4'd10, 4'd0, 4'd15,
                    wlft_pkg::MONTH_BITS'($urandom_range(1, 12))};

    send_idle_pct = 21;
    recv_idle_pct = 82;

    // Directed part on reset settings (start year 0, water year from October).
    queue_sample(0, 9, 30, '0);        // primes only
    queue_sample(0, 0, 0, '1);         // odd month and day codes, full-scale flow
    queue_sample(0, 15, 31, '1);
    queue_sample(0, 10, 1, '1);        // first water-year start: arm, no report
    queue_sample(0, 10, 2, '0);
    queue_sample(0, 11, 1, wlft_pkg::FLOW_BITS'(24'h123456));
    queue_sample(0, 12, 1, '0);
    queue_sample(1, 1, 1, '1);
    queue_sample(1, 10, 1, wlft_pkg::FLOW_BITS'(24'h000100));  // short year closes
    for (int k = 0; k < 11; k++)
      queue_sample((k < 2) ? 12'd1 : 12'd2, (10 + k) % 12 + 1, 1, draw_flow());
    queue_sample(2, 10, 1, draw_flow());             // full twelve-month year closes
    queue_sample(4095, 10, 1, wlft_pkg::FLOW_BITS'(7));  // top year closes a one-month year
    queue_sample(4095, 5, 17, '1);

    for (int p = 0; p < 6; p++) begin
      let_block_settle();
      case (p / 2)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_register(wlft_pkg::REG_START_YEAR,
                     wlft_pkg::APB_DATA_BITS'(start_table[p]));
      write_register(wlft_pkg::REG_WY_MONTH,
                     wlft_pkg::APB_DATA_BITS'(month_table[p]));
      @(negedge clk_i);

      // Mostly well-formed seasons; the rest bursts and noise.
      while (samples_to_send.size() < PHASE_ITEMS) begin
        case ($urandom_range(9))
          7:       queue_month_start_burst();
          8, 9:    queue_noise($urandom_range(3, 15));
          default: queue_season();
        endcase
      end
    end

    let_block_settle();
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/wlft_pkg.sv
rtl/wlft_ram.sv
rtl/wlft_cfg.sv
rtl/wlft_avg.sv
rtl/weekly_low_flow_tracker_unit.sv
bench/tb_weekly_low_flow_tracker_unit.sv
